// File: rtl/core/sine_carrier_sample_mixer_macros.svh
// Assertion macros shared by the mixer RTL.
`ifndef SINE_CARRIER_SAMPLE_MIXER_MACROS_SVH
`define SINE_CARRIER_SAMPLE_MIXER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SCSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SCSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/scsm_pkg.sv
// Package: constants and sine table generator for the sine carrier mixer.
`timescale 1ns / 1ps

package scsm_pkg;

    localparam int unsigned PHASE_WIDTH_DEF    = 32;
    localparam int unsigned SINE_ADDR_BITS_DEF = 10;
    localparam int unsigned SAMPLE_W           = 16;
    localparam int unsigned STEP_W             = 32;

    localparam logic [STEP_W-1:0] STEP_RESET   = 32'd1246611823;
    localparam logic [63:0]       HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0]       CARRIER_PEAK = 64'd32767;
    localparam logic [63:0]       Q30_ONE      = 64'd1 << 30;

    // 32767 * sin(j * (pi/2) / 2^qbits), Taylor series to x^11 in Q2.30.
    // Evaluated at elaboration only.
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input int unsigned j,
                                                         input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        x  = (64'(j) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        h  = Q30_ONE - x2 / 64'd110;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
        s  = (x * h) >> 30;
        s  = (s * CARRIER_PEAK + (Q30_ONE >> 1)) >> 30;
        if (s > CARRIER_PEAK)
        begin
            s = CARRIER_PEAK;
        end
        return s[SAMPLE_W-1:0];
    endfunction

endpackage

// File: rtl/core/scsm_sine_rom.sv
// Quarter-wave sine table with quadrant folding and a registered read.
`timescale 1ns / 1ps

module scsm_sine_rom
    import scsm_pkg::*;
#(
    parameter int unsigned ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [ADDR_BITS-1:0]       addr,
    output logic signed [SAMPLE_W-1:0] carrier
);

    localparam int unsigned QB = ADDR_BITS - 2;
    localparam int unsigned QS = 1 << QB;
    localparam logic [QB:0] QS_IDX = (QB + 1)'(QS);

    logic [SAMPLE_W-1:0]        quarter_rom [QS+1];
    logic [1:0]                 quad;
    logic [QB-1:0]              rem;
    logic [QB:0]                idx;
    logic [SAMPLE_W-1:0]        mag;
    logic signed [SAMPLE_W-1:0] carrier_next;
    logic signed [SAMPLE_W-1:0] carrier_reg;

    for (genvar k = 0; k <= QS; k++)
    begin : g_rom
        assign quarter_rom[k] = quarter_sine(k, QB);
    end

    // Second and fourth quadrants run the quarter wave backward; the second
    // half of the turn is negated.
    always_comb
    begin
        quad = addr[ADDR_BITS-1 -: 2];
        rem  = addr[QB-1:0];
        idx  = quad[0] ? (QS_IDX - {1'b0, rem}) : {1'b0, rem};
        mag  = quarter_rom[idx];
        carrier_next = quad[1] ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carrier_reg <= carrier_next;
        end
    end

    assign carrier = carrier_reg;

endmodule

// File: rtl/core/sine_carrier_sample_mixer.sv
// Sine carrier mixer: NCO phase accumulator, sine lookup and sample multiply.
`timescale 1ns / 1ps
// Takes one signed 16-bit sample per transfer and returns sample * sin(phase)
// in Q1.15, truncated toward zero, so outputs stay within -32767..32767. The
// phase starts at zero after reset (first output is 0) and advances by
// phase_step after every accepted sample, wrapping at 2^PHASE_WIDTH; the
// reset step gives a 12800 Hz carrier at 44100 Hz sampling. One sample is
// taken every clock cycle unless the output is stalled; a result passes the
// input register, the registered sine table read, and the multiply and
// truncate into the output register before m_tvalid rises for it. A result
// held by m_tready low stalls the whole pipeline.
// Write phase_step only while no samples are in flight.

module sine_carrier_sample_mixer
    import scsm_pkg::*;
#(
    parameter int unsigned PHASE_WIDTH    = PHASE_WIDTH_DEF,
    parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STEP_W-1:0]   cfg_data,      // phase_step
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,       // [15:0] sample_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata        // [15:0] sample_out
);

`include "sine_carrier_sample_mixer_macros.svh"

    logic [STEP_W-1:0]          phase_step_reg;
    logic [PHASE_WIDTH-1:0]     phase_acc_reg;
    logic [PHASE_WIDTH-1:0]     phase_acc_next;

    logic                       en;
    logic                       in_xfer;

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample1_reg;
    logic signed [SAMPLE_W-1:0] sample2_reg;
    logic [SINE_ADDR_BITS-1:0]  addr1_reg;
    logic signed [SAMPLE_W-1:0] carrier;

    logic signed [31:0]         prod;
    logic signed [31:0]         prod_biased;
    logic [SAMPLE_W-1:0]        out_next;
    logic [SAMPLE_W-1:0]        out_reg;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign in_xfer   = s_tvalid && en;
    assign cfg_ready = 1'b1;

    assign phase_acc_next = phase_acc_reg + PHASE_WIDTH'(phase_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= STEP_RESET;
            phase_acc_reg  <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                phase_step_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                phase_acc_reg <= phase_acc_next;
            end
            if (en)
            begin
                v1_reg        <= s_tvalid;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Payload pipeline; the phase used is the one before this sample's step.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample1_reg <= $signed(s_tdata);
            addr1_reg   <= phase_acc_reg[PHASE_WIDTH-1 -: SINE_ADDR_BITS];
            sample2_reg <= sample1_reg;
            out_reg     <= out_next;
        end
    end

    scsm_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .en      (en),
        .addr    (addr1_reg),
        .carrier (carrier)
    );

    // Shift right by 15, rounding negative products toward zero.
    always_comb
    begin
        prod        = 32'(sample2_reg) * 32'(carrier);
        prod_biased = prod + (prod[31] ? 32'sd32767 : 32'sd0);
        out_next    = prod_biased[30:15];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `SCSM_ASSERT_NEXT(a_phase_hold, !in_xfer && !(cfg_valid && cfg_ready),
        $stable(phase_acc_reg) && $stable(phase_step_reg),
        "phase state changed without a transfer")
    `SCSM_ASSERT_NEXT(a_pipe_advance, en && v2_reg, m_tvalid,
        "result lost between stages")
    `SCSM_ASSERT_NOW(a_out_range, m_tvalid, m_tdata != 16'h8000,
        "sample_out reached -32768")
    `SCSM_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, !v1_reg || $past(v1_reg),
        "pipeline moved while stalled")

endmodule

// File: test/sine_carrier_sample_mixer_tb.sv
// Self-checking testbench for the sine carrier sample mixer.
`timescale 1ns / 1ps

module sine_carrier_sample_mixer_tb;
    import scsm_pkg::*;

    localparam int LUT_BITS        = 10;
    localparam int LUT_SIZE        = 1 << LUT_BITS;
    localparam int QTR_BITS        = LUT_BITS - 2;
    localparam int QTR_SIZE        = 1 << QTR_BITS;
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30        = 64'd1 << 30;
    localparam longint unsigned PEAK            = 64'd32767;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int LONG_HOLD       = 64;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int DIRECTED_ROWS   = 25;

    typedef enum logic
    {
        ROW_SAMPLE = 1'b0,
        ROW_STEP   = 1'b1
    } row_kind_t;

    // value is the tuning word for a step row, the sample (low bits) otherwise
    typedef struct packed
    {
        row_kind_t           kind;
        logic                typed;
        logic [STEP_W-1:0]   value;
        logic [SAMPLE_W-1:0] mixed;
    } stim_row_t;

    typedef struct packed
    {
        logic                typed;
        logic [SAMPLE_W-1:0] mixed;
    } row_expect_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [STEP_W-1:0]   cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;

    int                  carrier_lut [LUT_SIZE];
    logic [STEP_W-1:0]   osc_phase;
    logic [STEP_W-1:0]   osc_step;
    logic [SAMPLE_W-1:0] mixed_q [$];
    row_expect_t         typed_q [$];

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    logic hold_arm   = 1'b0;
    bit   hold_done  = 1'b0;
    int   hold_left  = 0;
    int   failures   = 0;
    int   checked    = 0;
    int   steps_used = 0;

    // Phase 0 with step 0 keeps the carrier at zero; a quarter-turn step then
    // visits 0, +peak, 0, -peak so the extremes can be read off directly.
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_STEP,   1'b0, 32'h0000_0000, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_8000, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_7FFF, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_FFFF, 16'h0000},
        '{ROW_STEP,   1'b0, 32'h4000_0000, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_7FFF, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_7FFF, 16'sd32766},
        '{ROW_SAMPLE, 1'b1, 32'h0000_7FFF, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_7FFF, -16'sd32766},
        '{ROW_SAMPLE, 1'b1, 32'h0000_8000, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_8000, -16'sd32767},
        '{ROW_SAMPLE, 1'b1, 32'h0000_8000, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 32'h0000_8000, 16'sd32767},
        '{ROW_SAMPLE, 1'b1, 32'h0000_0001, 16'h0000},
        // -1 times full scale truncates toward zero
        '{ROW_SAMPLE, 1'b1, 32'h0000_FFFF, 16'h0000},
        '{ROW_STEP,   1'b0, 32'hFFFF_FFFF, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_5555, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_AAAA, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_0001, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_FFFF, 16'h0000},
        '{ROW_STEP,   1'b0, STEP_RESET,    16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_4000, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_C000, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_7FFF, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 32'h0000_8000, 16'h0000}
    };

    sine_carrier_sample_mixer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Quarter-wave sine in Q2.30, Horner form of the Taylor series to x^11.
    function automatic int quarter_wave(input int unsigned j);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned acc;
        longint unsigned divs [5];
        divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        ang  = (64'(j) * RIGHT_ANGLE_Q30) >> QTR_BITS;
        ang2 = (ang * ang) >> 30;
        acc  = UNIT_Q30;
        foreach (divs[d])
        begin
            acc = UNIT_Q30 - ((ang2 * acc) >> 30) / divs[d];
        end
        acc = (ang * acc) >> 30;
        acc = (acc * PEAK + (UNIT_Q30 >> 1)) >> 30;
        if (acc > PEAK)
        begin
            acc = PEAK;
        end
        return int'(acc);
    endfunction

    initial
    begin
        int quad;
        int r;
        int mag;
        for (int k = 0; k < LUT_SIZE; k++)
        begin
            quad = k >> QTR_BITS;
            r    = k & (QTR_SIZE - 1);
            mag  = quad[0] ? quarter_wave(QTR_SIZE - r) : quarter_wave(r);
            carrier_lut[k] = quad[1] ? -mag : mag;
        end
    end

    // Sample times carrier at the current phase, in Q1.15, truncated toward zero.
    function automatic logic [SAMPLE_W-1:0] mix_predict(input logic [SAMPLE_W-1:0] raw);
        int prod;
        int quo;
        prod = int'($signed(raw)) * carrier_lut[osc_phase[STEP_W-1 -: LUT_BITS]];
        quo  = (prod < 0) ? -((-prod) >>> 15) : (prod >>> 15);
        return quo[SAMPLE_W-1:0];
    endfunction

    // Input side: track the oscillator and queue the expected mixed samples.
    always @(posedge clk or negedge rst_n)
    begin
        row_expect_t row;
        logic [SAMPLE_W-1:0] guess;
        if (!rst_n)
        begin
            osc_phase = '0;
            osc_step  = STEP_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                row   = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
                guess = mix_predict(s_tdata);
                mixed_q.push_back(row.typed ? row.mixed : guess);
                osc_phase = osc_phase + osc_step;
            end
            // a new step takes effect from the next sample on
            if (cfg_valid && cfg_ready)
            begin
                osc_step = cfg_data;
            end
        end
    end

    // Output side: compare each transfer, then decide the next ready.
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mixed_q.size() == 0)
            begin
                if (failures < MAX_REPORTS)
                begin
                    $display("%0t: unexpected output %0d", $realtime, $signed(m_tdata));
                end
                failures++;
            end
            else
            begin
                want = mixed_q.pop_front();
                checked++;
                if (m_tdata !== want)
                begin
                    if (failures < MAX_REPORTS)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $realtime, $signed(want), $signed(m_tdata));
                    end
                    failures++;
                end
            end
        end
        if (hold_arm && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer_sample(input logic [SAMPLE_W-1:0] raw, input logic typed,
                                input logic [SAMPLE_W-1:0] mixed);
        typed_q.push_back(row_expect_t'{typed, mixed});
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (mixed_q.size() != 0);
    endtask

    task automatic load_step(input logic [STEP_W-1:0] word);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        steps_used++;
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] raw;
        logic [STEP_W-1:0]   word;
        int unsigned         pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_STEP)
            begin
                load_step(directed[i].value);
            end
            else
            begin
                offer_sample(directed[i].value[SAMPLE_W-1:0], directed[i].typed,
                             directed[i].mixed);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: word = STEP_RESET;
                1: word = $urandom();
                2: word = 32'hFFFF_FFFF;
                3: word = 32'h0100_0000;
                4: word = 32'h0000_0000;
                5: word = 32'h8000_0000;
                6: word = $urandom_range(32'h0040_0000);
                default: word = $urandom();
            endcase
            load_step(word);
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 52;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 52;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long output hold while input keeps coming; later a full drain
                if (ph == 0 && n == 40)
                begin
                    hold_arm <= 1'b1;
                end
                if (ph == 1 && n == 80)
                begin
                    wait_drained();
                end
                pick = $urandom_range(9);
                if (pick < 6)
                begin
                    raw = 16'($urandom());
                end
                else if (pick < 8)
                begin
                    raw = 16'($urandom_range(511)) - 16'd256;
                end
                else
                begin
                    case ($urandom_range(3))
                        0: raw = 16'h7FFF;
                        1: raw = 16'h8000;
                        2: raw = 16'hFFFF;
                        default: raw = 16'h0001;
                    endcase
                end
                offer_sample(raw, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Mixed %0d samples across %0d tuning words (zero, half turn, full scale,",
                 checked, steps_used);
        $display("reset rate, random) under idle/stall mixes, a long hold and a drain pause");
        if (failures == 0 && mixed_q.size() == 0 && typed_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sine_carrier_sample_mixer.f
+incdir+rtl/core
rtl/core/scsm_pkg.sv
rtl/core/scsm_sine_rom.sv
rtl/core/sine_carrier_sample_mixer.sv
test/sine_carrier_sample_mixer_tb.sv
